// ===== rtl/ibd_pkg.sv =====
// Package for the idle backlight dimmer.
// Holds the sequencer state type, the action and register codes and the stream field layout.
// No dependencies.
package ibd_pkg;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RAMP
	} state_t;

	typedef enum logic [1:0] {
		ACT_TICK     = 2'd0,
		ACT_ACTIVITY = 2'd1,
		ACT_SET      = 2'd2,
		ACT_NONE     = 2'd3
	} action_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_WAIT_TICKS = 2'd0;
	localparam logic [1:0] REG_DARK_LEVEL = 2'd1;
	localparam logic [1:0] REG_MAX_LEVEL  = 2'd2;
	localparam logic [1:0] REG_FORCE_MODE = 2'd3;

	// Force mode thresholds: dimming at max level needs at least FORCE_AT_MAX,
	// dimming on AC needs at least FORCE_ON_AC.
	localparam logic [1:0] FORCE_AT_MAX = 2'd1;
	localparam logic [1:0] FORCE_ON_AC  = 2'd2;

	// Ticks after a ramp during which user level changes are ignored.
	localparam logic [1:0] GATE_TICKS = 2'd2;

	// Field widths and positions on the streams.
	localparam int FIELD_W      = 6;
	localparam int IN_AC_POS    = 6;
	localparam int IN_REQ_POS   = 7;
	localparam int IN_DATA_W    = 16;
	localparam int OUT_DATA_W   = 8;
	localparam int WAIT_W       = 16;
	localparam int DARK_W       = 3;
	localparam int CFG_DATA_W   = 16;

endpackage

// ===== rtl/idle_backlight_dimmer.sv =====
// Idle backlight dimmer top level.
// Depends on ibd_pkg for codes, field layout and the sequencer state type.
//
// Usage: the slave stream takes one request per event: s_axis_tuser is the action
// (one-second tick, user activity, user level change) and s_axis_tdata carries the
// level read back from the panel, the AC flag and the level the user selected.
// Every request that starts a ramp produces a run of level steps on the master
// stream, one level apart, from the panel level to the target; m_axis_tlast marks
// the final step. Requests that start no ramp only update the idle state.
// Throughput: a request that starts no ramp leaves s_axis_tready high. A ramp holds it
// low until its last step is in the output register, one step per cycle while the
// receiver does not stall, from a single up/down level stepper; the widest ramp has 64
// steps. The first step passes from the stepper register into the output register.
// The master stream has an output register: when the receiver stalls, the step in
// the register holds and the stepper waits; the last step may still sit there while
// the next request is taken.
// Reset (arst_n low) loads the register reset values, clears the dim state, arms the
// idle countdown with the wait time and empties the output register.
// Configuration writes (cfg_we, cfg_index, cfg_data) are taken in any cycle and are
// meant to happen while no ramp is running; a new wait time applies at the next rearm.
module idle_backlight_dimmer
	import ibd_pkg::*;
#(
	parameter int LEVEL_BITS = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [5:0] actual_level, [6] on_ac, [12:7] new_level, [15:13] zero
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// [1:0] action
	input  logic [1:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [5:0] drive_level, [7:6] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef logic [LEVEL_BITS-1:0] level_t;

	// Configuration registers.
	logic [WAIT_W-1:0] wait_ticks_q;
	logic [DARK_W-1:0] dark_level_q;
	logic [FIELD_W-1:0] max_level_q;
	logic [1:0]        force_mode_q;

	// Idle state.
	logic              dark_flag_q, dark_flag_d;
	level_t            before_dim_q, before_dim_d;
	level_t            saved_q, saved_d;
	logic [WAIT_W-1:0] countdown_q, countdown_d;
	logic              armed_q, armed_d;
	logic [1:0]        gate_q, gate_d;

	// Sequencer and stepper.
	state_t            state_q, state_d;
	level_t            lv_q, tgt_q, lv_step;
	logic              ramp_go;
	level_t            ramp_from, ramp_to;
	logic              accept, load_out, at_target;

	// Output register.
	logic              out_valid_q, out_valid_d;
	level_t            out_level_q;
	logic              out_last_q;

	action_t           act;
	level_t            actual, req, dark, top;
	logic              ac;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign act    = action_t'(s_axis_tuser);
	assign actual = s_axis_tdata[LEVEL_BITS-1:0];
	assign ac     = s_axis_tdata[IN_AC_POS];
	assign req    = s_axis_tdata[IN_REQ_POS +: LEVEL_BITS];
	assign dark   = LEVEL_BITS'(dark_level_q);
	assign top    = max_level_q[LEVEL_BITS-1:0];

	// Decision on one request: next idle state and whether a ramp starts.
	always_comb begin
		dark_flag_d  = dark_flag_q;
		before_dim_d = before_dim_q;
		saved_d      = saved_q;
		countdown_d  = countdown_q;
		armed_d      = armed_q;
		gate_d       = gate_q;
		ramp_go      = 1'b0;
		ramp_from    = actual;
		ramp_to      = dark;
		case (act)
			ACT_TICK: begin
				if (gate_q < GATE_TICKS) begin
					gate_d = gate_q + 2'd1;
				end
				if (armed_q) begin
					if (countdown_q > WAIT_W'(1)) begin
						countdown_d = countdown_q - WAIT_W'(1);
					end else begin
						countdown_d = '0;
						armed_d     = 1'b0;
						if (!dark_flag_q) begin
							if ((ac && force_mode_q < FORCE_ON_AC) ||
							    (actual == top && force_mode_q < FORCE_AT_MAX)) begin
								countdown_d = wait_ticks_q;
								armed_d     = 1'b1;
							end else begin
								before_dim_d = actual;
								saved_d      = dark;
								ramp_go      = 1'b1;
								ramp_to      = dark;
								dark_flag_d  = 1'b1;
							end
						end
					end
				end
			end
			ACT_ACTIVITY: begin
				countdown_d = wait_ticks_q;
				armed_d     = 1'b1;
				if (dark_flag_q) begin
					if (actual > before_dim_q) begin
						saved_d = actual;
					end else begin
						saved_d = before_dim_q;
						ramp_go = 1'b1;
						ramp_to = before_dim_q;
					end
					dark_flag_d = 1'b0;
				end
			end
			ACT_SET: begin
				if (saved_q != req && gate_q >= GATE_TICKS) begin
					countdown_d = wait_ticks_q;
					armed_d     = 1'b1;
					if (dark_flag_q && req > dark) begin
						ramp_go     = 1'b1;
						ramp_to     = top;
						dark_flag_d = 1'b0;
					end else if (req < dark) begin
						ramp_go = 1'b1;
						ramp_to = dark;
					end
					saved_d = req;
				end
			end
			default: begin
			end
		endcase
		if (ramp_go) begin
			gate_d = '0;
		end
	end

	// Shared up/down stepper.
	assign at_target = (lv_q == tgt_q);
	assign lv_step   = (lv_q < tgt_q) ? lv_q + level_t'(1) : lv_q - level_t'(1);
	assign load_out  = (state_q == ST_RAMP) && (!out_valid_q || m_axis_tready);

	always_comb begin
		state_d     = state_q;
		out_valid_d = out_valid_q;
		if (m_axis_tready) begin
			out_valid_d = 1'b0;
		end
		case (state_q)
			ST_IDLE: begin
				if (accept && ramp_go) begin
					state_d = ST_RAMP;
				end
			end
			ST_RAMP: begin
				if (load_out) begin
					out_valid_d = 1'b1;
					if (at_target) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_ticks_q <= WAIT_W'(3);
			dark_level_q <= '0;
			max_level_q  <= FIELD_W'(63);
			force_mode_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WAIT_TICKS: wait_ticks_q <= cfg_data[WAIT_W-1:0];
				REG_DARK_LEVEL: dark_level_q <= cfg_data[DARK_W-1:0];
				REG_MAX_LEVEL:  max_level_q  <= cfg_data[FIELD_W-1:0];
				REG_FORCE_MODE: force_mode_q <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_flag_q  <= 1'b0;
			before_dim_q <= '0;
			saved_q      <= '0;
			countdown_q  <= WAIT_W'(3);
			armed_q      <= 1'b1;
			gate_q       <= GATE_TICKS;
		end else if (accept) begin
			dark_flag_q  <= dark_flag_d;
			before_dim_q <= before_dim_d;
			saved_q      <= saved_d;
			countdown_q  <= countdown_d;
			armed_q      <= armed_d;
			gate_q       <= gate_d;
		end
	end

	// Stepper and output payload registers.
	always_ff @(posedge clk) begin
		if (accept && ramp_go) begin
			lv_q  <= ramp_from;
			tgt_q <= ramp_to;
		end else if (load_out) begin
			lv_q <= lv_step;
		end
		if (load_out) begin
			out_level_q <= lv_q;
			out_last_q  <= at_target;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'(out_level_q);
	assign m_axis_tlast  = out_last_q;

endmodule

// ===== rtl/ibd_checker.sv =====
// Port checker for the idle backlight dimmer, bound to the top level.
// Depends on ibd_pkg for the stream widths.
module ibd_checker
	import ibd_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic                  m_axis_tlast
);

	// A stalled step holds its level and end mark.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled ramp step changed");

	// No request is taken while a ramp is only part way out.
	a_busy_mid_ramp: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("request taken in the middle of a ramp");

	// The step after a taken non-final step follows in the next cycle.
	a_ramp_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
		else $error("gap inside a ramp");

	// The pad bits above the level stay zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:FIELD_W] == '0)
		else $error("nonzero pad bits on drive level");

endmodule

bind idle_backlight_dimmer ibd_checker u_ibd_checker (.*);

// ===== bench/idle_backlight_dimmer_tb.sv =====
// Self-checking bench for the idle backlight dimmer: directed and random events on the slave
// stream, ramp steps checked on the master stream against a behavioral tracker of the dimmer.
// Depends on ibd_pkg and idle_backlight_dimmer.
module idle_backlight_dimmer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ibd_pkg::*;

	localparam int QUIET_LIMIT = 4000;

	typedef struct {
		logic [5:0] level;
		bit         is_last;
	} level_step_t;

	// Tracks the dimmer's idle state and registers, and holds the ramp steps still owed.
	class backlight_tracker;
		logic [15:0] wait_ticks;
		logic [2:0]  dark_level;
		logic [5:0]  max_level;
		logic [1:0]  force_mode;

		bit          dark;
		logic [5:0]  level_before_dim;
		logic [5:0]  saved_level;
		logic [15:0] countdown;
		bit          armed;
		logic [1:0]  ticks_since_ramp;
		logic [5:0]  ramp_pos;

		level_step_t due_steps[$];
		int          errors;
		int          requests;
		int          steps;
		int          ramps;

		function void reset_state();
			wait_ticks = 16'd3;
			dark_level = 3'd0;
			max_level = 6'd63;
			force_mode = 2'd0;
			dark = 0;
			level_before_dim = 6'd0;
			saved_level = 6'd0;
			countdown = wait_ticks;
			armed = 1;
			ticks_since_ramp = GATE_TICKS;
			ramp_pos = 6'd0;
			due_steps.delete();
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				REG_WAIT_TICKS: wait_ticks = val;
				REG_DARK_LEVEL: dark_level = val[2:0];
				REG_MAX_LEVEL:  max_level = val[5:0];
				REG_FORCE_MODE: force_mode = val[1:0];
				default: ;
			endcase
		endfunction

		function void rearm();
			countdown = wait_ticks;
			armed = 1;
		endfunction

		function void queue_ramp(logic [5:0] from, logic [5:0] to);
			logic [5:0] lv;
			lv = from;
			ticks_since_ramp = 2'd0;
			due_steps.push_back('{lv, lv == to});
			while (lv != to) begin
				lv = (lv < to) ? lv + 6'd1 : lv - 6'd1;
				due_steps.push_back('{lv, lv == to});
			end
			ramp_pos = to;
			ramps++;
		endfunction

		function void take_event(action_t act, logic [5:0] actual, bit ac, logic [5:0] req);
			logic [5:0] dark_lv;
			dark_lv = {3'd0, dark_level};
			requests++;
			case (act)
				ACT_TICK: begin
					if (ticks_since_ramp < GATE_TICKS)
						ticks_since_ramp++;
					if (armed) begin
						if (countdown > 16'd1) begin
							countdown--;
						end else begin
							countdown = 16'd0;
							armed = 0;
							// A countdown running out while dark only disarms it.
							if (!dark) begin
								if (ac && force_mode < FORCE_ON_AC) begin
									rearm();
								end else if (actual == max_level && force_mode < FORCE_AT_MAX) begin
									rearm();
								end else begin
									level_before_dim = actual;
									saved_level = dark_lv;
									queue_ramp(actual, dark_lv);
									dark = 1;
								end
							end
						end
					end
				end
				ACT_ACTIVITY: begin
					rearm();
					if (dark) begin
						if (actual > level_before_dim) begin
							saved_level = actual;
						end else begin
							saved_level = level_before_dim;
							queue_ramp(actual, level_before_dim);
						end
						dark = 0;
					end
				end
				ACT_SET: begin
					if (saved_level != req && ticks_since_ramp >= GATE_TICKS) begin
						rearm();
						if (dark && req > dark_lv) begin
							queue_ramp(actual, max_level);
							dark = 0;
						end else if (req < dark_lv) begin
							queue_ramp(actual, dark_lv);
						end
						saved_level = req;
					end
				end
				default: ;
			endcase
		endfunction

		function void check_level_step(logic [5:0] level, logic is_last);
			level_step_t exp;
			steps++;
			if (due_steps.size() == 0) begin
				$display("%0t: unexpected level step, level %0d last %0b", $time, level, is_last);
				errors++;
			end else begin
				exp = due_steps.pop_front();
				if (level !== exp.level) begin
					$display("%0t: drive_level expected %0d, got %0d", $time, exp.level, level);
					errors++;
				end
				if (is_last !== exp.is_last) begin
					$display("%0t: last_step expected %0b, got %0b", $time, exp.is_last, is_last);
					errors++;
				end
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [1:0]            s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  cfg_we;
	logic [1:0]            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	backlight_tracker tracker;
	bit               calm;
	int               quiet_cycles;
	int               settings;

	idle_backlight_dimmer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Requests are noted before steps are checked; a step never shares an edge with its request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				tracker.take_event(action_t'(s_axis_tuser), s_axis_tdata[5:0],
					s_axis_tdata[IN_AC_POS], s_axis_tdata[IN_REQ_POS +: FIELD_W]);
			if (m_axis_tvalid && m_axis_tready)
				tracker.check_level_step(m_axis_tdata[5:0], m_axis_tlast);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("%0t: no request or step moved for %0d cycles", $time, QUIET_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Receiver: runs of ready broken by stalls, mostly short and now and then long; always ready when calm.
	initial begin
		int run;
		wait (arst_n);
		forever begin
			if (calm) begin
				@(negedge clk) m_axis_tready <= 1'b1;
			end else begin
				run = $urandom_range(1, 8);
				@(negedge clk) m_axis_tready <= 1'b1;
				repeat (run - 1) @(negedge clk);
				run = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
				@(negedge clk) m_axis_tready <= 1'b0;
				repeat (run - 1) @(negedge clk);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_req(action_t act, logic [5:0] actual, bit ac, logic [5:0] req);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk) s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= {3'd0, req, ac, actual};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Stops the source and waits until every owed step is out and the block has gone quiet.
	task automatic settle();
		@(negedge clk) s_axis_tvalid <= 1'b0;
		while (tracker.due_steps.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		tracker.write_reg(idx, val);
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	task automatic send_random();
		int         r;
		action_t    act;
		logic [5:0] actual;
		logic [5:0] req;
		bit         ac;
		r = $urandom_range(0, 99);
		if (r < 48)
			act = ACT_TICK;
		else if (r < 70)
			act = ACT_ACTIVITY;
		else if (r < 95)
			act = ACT_SET;
		else
			act = ACT_NONE;
		// Mostly the panel reads back what the block last drove.
		r = $urandom_range(0, 99);
		if (r < 65)
			actual = tracker.ramp_pos;
		else if (r < 77)
			actual = tracker.max_level;
		else if (r < 82)
			actual = ($urandom_range(0, 1) != 0) ? 6'd63 : 6'd0;
		else
			actual = 6'($urandom);
		ac = ($urandom_range(0, 3) == 0);
		r = $urandom_range(0, 99);
		if (r < 20)
			req = tracker.saved_level;
		else if (r < 40 && tracker.dark_level != 3'd0)
			req = 6'($urandom_range(0, int'(tracker.dark_level) - 1));
		else if (r < 50)
			req = tracker.max_level;
		else if (r < 55)
			req = {3'd0, tracker.dark_level};
		else
			req = 6'($urandom);
		send_req(act, actual, ac, req);
	endtask

	task automatic run_phase(logic [15:0] wait_t, logic [2:0] dark_l, logic [5:0] max_l,
			logic [1:0] force_m, int count, bit no_idle);
		settle();
		write_reg(REG_WAIT_TICKS, wait_t);
		write_reg(REG_DARK_LEVEL, {13'd0, dark_l});
		write_reg(REG_MAX_LEVEL, {10'd0, max_l});
		write_reg(REG_FORCE_MODE, {14'd0, force_m});
		settings++;
		calm = no_idle;
		repeat (count) send_random();
	endtask

	initial begin
		tracker = new();
		tracker.reset_state();
		calm = 0;
		quiet_cycles = 0;
		settings = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = ACT_TICK;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_WAIT_TICKS;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Directed part: a one-tick wait so that every armed tick fires.
		write_reg(REG_WAIT_TICKS, 16'd1);
		write_reg(REG_DARK_LEVEL, 16'd0);
		write_reg(REG_MAX_LEVEL, 16'd63);
		write_reg(REG_FORCE_MODE, 16'd0);
		settings++;
		send_req(ACT_NONE, 6'd63, 1'b1, 6'd63);
		send_req(ACT_ACTIVITY, 6'd10, 1'b0, 6'd0);
		send_req(ACT_TICK, 6'd63, 1'b0, 6'd0);   // at max level: rearm only
		send_req(ACT_TICK, 6'd10, 1'b1, 6'd0);   // on AC: rearm only
		send_req(ACT_TICK, 6'd10, 1'b0, 6'd0);   // dims 10 down to 0
		send_req(ACT_SET, 6'd0, 1'b0, 6'd5);     // too soon after the ramp
		send_req(ACT_TICK, 6'd0, 1'b0, 6'd0);
		send_req(ACT_ACTIVITY, 6'd0, 1'b0, 6'd0);
		send_req(ACT_TICK, 6'd10, 1'b0, 6'd0);
		send_req(ACT_TICK, 6'd0, 1'b0, 6'd0);
		send_req(ACT_TICK, 6'd0, 1'b0, 6'd0);
		send_req(ACT_SET, 6'd0, 1'b0, 6'd0);     // equal to the saved level
		send_req(ACT_SET, 6'd0, 1'b0, 6'd40);    // raise while dark jumps to max
		send_req(ACT_TICK, 6'd63, 1'b0, 6'd0);
		send_req(ACT_TICK, 6'd63, 1'b0, 6'd0);
		send_req(ACT_SET, 6'd63, 1'b0, 6'd63);
		settle();
		write_reg(REG_DARK_LEVEL, 16'd5);
		write_reg(REG_FORCE_MODE, {14'd0, FORCE_ON_AC});
		settings++;
		send_req(ACT_TICK, 6'd63, 1'b1, 6'd0);   // dims on AC at max
		send_req(ACT_TICK, 6'd5, 1'b0, 6'd0);
		send_req(ACT_TICK, 6'd5, 1'b0, 6'd0);
		send_req(ACT_SET, 6'd5, 1'b0, 6'd2);     // below dark: one-step ramp to dark
		send_req(ACT_TICK, 6'd5, 1'b0, 6'd0);    // fires while dark
		send_req(ACT_TICK, 6'd5, 1'b0, 6'd0);
		send_req(ACT_ACTIVITY, 6'd0, 1'b0, 6'd0);
		send_req(ACT_TICK, 6'd30, 1'b0, 6'd0);
		send_req(ACT_ACTIVITY, 6'd45, 1'b0, 6'd0); // user went brighter: adopted

		run_phase(16'd1, 3'd0, 6'd63, 2'd0, 40, 1'b0);
		run_phase(16'd2, 3'd5, 6'd63, 2'd1, 40, 1'b0);
		run_phase(16'd3, 3'd2, 6'd40, 2'd2, 40, 1'b1);
		run_phase(16'd0, 3'd1, 6'd1, 2'd3, 40, 1'b0);
		run_phase(16'd4, 3'd5, 6'd20, 2'd0, 40, 1'b0);
		run_phase(16'hFFFF, 3'd3, 6'd63, 2'd2, 20, 1'b0);
		run_phase(16'd2, 3'd0, 6'd63, 2'd1, 40, 1'b0);
		run_phase(16'd1, 3'd4, 6'd10, 2'd2, 60, 1'b0);

		settle();
		repeat (20) @(posedge clk);
		if (tracker.due_steps.size() != 0) begin
			$display("%0t: %0d level steps never arrived", $time, tracker.due_steps.size());
			tracker.errors++;
		end
		$display("Covered %0d requests and %0d level steps in %0d ramps under %0d settings.",
			tracker.requests, tracker.steps, tracker.ramps, settings);
		if (tracker.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
